### sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define CPO_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");
// overlapping implication
`define CPO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("%m: assertion failed");
// implication, consequent in the next cycle
`define CPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define CPO_ASSERT(label, clk, rst_n, cond)
`define CPO_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CPO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/cpo_pkg.sv
// types and constants of the collider pair overlap tester
`default_nettype none

package cpo_pkg;

    // item operation
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TEST  = 1'b1
    } op_t;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_WRITE         = 2'd0,
        OUT_TESTED        = 2'd1,
        OUT_SKIP_DISABLED = 2'd2,
        OUT_SKIP_LAYER    = 2'd3
    } outcome_t;

    localparam int AXES    = 3;
    localparam int IDX_W   = 8;
    localparam int POS_W   = 32;
    localparam int EXT_W   = 31;
    localparam int LAYER_W = 8;
    // centre plus or minus extent, signed
    localparam int BOUND_W = 34;
    // every axis distance fits in 32 bits unsigned
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;

    // geometry of one table entry, axis 0 is x
    typedef struct packed {
        logic [AXES-1:0][POS_W-1:0] pos;
        logic [AXES-1:0][EXT_W-1:0] ext;
    } geom_t;

    // attribute word, enabled flag in bit 0
    typedef struct packed {
        logic [LAYER_W-1:0] mask;
        logic [LAYER_W-1:0] layer;
        logic               sphere;
        logic               enabled;
    } attr_t;

    // control that travels with an item into the geometry pipeline
    typedef struct packed {
        logic valid;
        logic is_test;
        logic range_a;
        logic range_b;
    } item_ctl_t;

endpackage

`default_nettype wire

### sv/cpo_store.sv
// collider table: geometry and attribute memories with registered reads
`default_nettype none
`include "assert_macros.svh"

module cpo_store #(
    parameter int ENTRIES = 256
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0]   wr_addr,
    input  wire cpo_pkg::geom_t               wr_geom,
    input  wire cpo_pkg::attr_t               wr_attr,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0]   rd_addr_a,
    input  wire logic [$clog2(ENTRIES)-1:0]   rd_addr_b,
    output cpo_pkg::geom_t                    rd_geom_a,
    output cpo_pkg::geom_t                    rd_geom_b,
    output cpo_pkg::attr_t                    rd_attr_a,
    output cpo_pkg::attr_t                    rd_attr_b,
    output logic                              clearing
);

    localparam int AW = $clog2(ENTRIES);

    cpo_pkg::geom_t geom_mem [ENTRIES];
    cpo_pkg::attr_t attr_mem [ENTRIES];

    cpo_pkg::geom_t rd_geom_a_reg;
    cpo_pkg::geom_t rd_geom_b_reg;
    cpo_pkg::attr_t rd_attr_a_reg;
    cpo_pkg::attr_t rd_attr_b_reg;

    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    logic           attr_we;
    logic [AW-1:0]  attr_addr;
    cpo_pkg::attr_t attr_wdata;

    // clearing pass walks the attribute table once after reset
    always_comb
    begin
        clearing_next = clearing_reg && (clr_addr_reg != AW'(ENTRIES - 1));
        clr_addr_next = clearing_reg ? clr_addr_reg + AW'(1) : clr_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // attribute write port shared with the clearing pass
    always_comb
    begin
        attr_we    = clearing_reg || wr_en;
        attr_addr  = clearing_reg ? clr_addr_reg : wr_addr;
        attr_wdata = clearing_reg ? '0 : wr_attr;
    end

    // geometry memory, one write and two reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            geom_mem[wr_addr] <= wr_geom;
        end
        if (rd_en)
        begin
            rd_geom_a_reg <= geom_mem[rd_addr_a];
            rd_geom_b_reg <= geom_mem[rd_addr_b];
        end
    end

    // attribute memory, one write and two reads
    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[attr_addr] <= attr_wdata;
        end
        if (rd_en)
        begin
            rd_attr_a_reg <= attr_mem[rd_addr_a];
            rd_attr_b_reg <= attr_mem[rd_addr_b];
        end
    end

    assign rd_geom_a = rd_geom_a_reg;
    assign rd_geom_b = rd_geom_b_reg;
    assign rd_attr_a = rd_attr_a_reg;
    assign rd_attr_b = rd_attr_b_reg;
    assign clearing  = clearing_reg;

    // an item write never lands on top of the clearing pass
    `CPO_ASSERT(a_no_write_while_clearing, clk, rst_n, !(clearing_reg && wr_en))

endmodule

`default_nettype wire

### sv/cpo_geom.sv
// pair classification and overlap pipeline, four register stages
`default_nettype none

module cpo_geom (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cpo_pkg::item_ctl_t ctl_in,
    input  wire cpo_pkg::geom_t     geom_a,
    input  wire cpo_pkg::geom_t     geom_b,
    input  wire cpo_pkg::attr_t     attr_a,
    input  wire cpo_pkg::attr_t     attr_b,
    output logic                    done,
    output logic                    contact,
    output logic [1:0]              outcome
);

    localparam int AXES    = cpo_pkg::AXES;
    localparam int BOUND_W = cpo_pkg::BOUND_W;
    localparam int EXT_W   = cpo_pkg::EXT_W;
    localparam int MAG_W   = cpo_pkg::MAG_W;
    localparam int SQ_W    = cpo_pkg::SQ_W;
    localparam int SUM_W   = cpo_pkg::SUM_W;

    // stage 1: entry checks and box bounds
    cpo_pkg::outcome_t        s1_outcome_next;
    logic signed [BOUND_W-1:0] a_c [AXES];
    logic signed [BOUND_W-1:0] b_c [AXES];
    logic signed [BOUND_W-1:0] a_lo_next [AXES];
    logic signed [BOUND_W-1:0] a_hi_next [AXES];
    logic signed [BOUND_W-1:0] b_lo_next [AXES];
    logic signed [BOUND_W-1:0] b_hi_next [AXES];
    cpo_pkg::attr_t            ta;
    cpo_pkg::attr_t            tb;

    logic                      s1_valid_reg;
    cpo_pkg::outcome_t         s1_outcome_reg;
    logic                      s1_sa_reg;
    logic                      s1_sb_reg;
    logic signed [BOUND_W-1:0] s1_ca_reg [AXES];
    logic signed [BOUND_W-1:0] s1_cb_reg [AXES];
    logic signed [BOUND_W-1:0] s1_a_lo_reg [AXES];
    logic signed [BOUND_W-1:0] s1_a_hi_reg [AXES];
    logic signed [BOUND_W-1:0] s1_b_lo_reg [AXES];
    logic signed [BOUND_W-1:0] s1_b_hi_reg [AXES];
    logic [EXT_W-1:0]          s1_ra_reg;
    logic [EXT_W-1:0]          s1_rb_reg;

    // stage 2: per axis distances and box compares
    logic [AXES-1:0]           bb_axis;
    logic signed [BOUND_W-1:0] d_ab [AXES];
    logic signed [BOUND_W-1:0] d_ba [AXES];
    logic signed [BOUND_W-1:0] sp [AXES];
    logic signed [BOUND_W-1:0] bx_lo [AXES];
    logic signed [BOUND_W-1:0] bx_hi [AXES];
    logic signed [BOUND_W-1:0] d_lo [AXES];
    logic signed [BOUND_W-1:0] d_hi [AXES];
    logic [MAG_W-1:0]          mag_next [AXES];
    logic [MAG_W-1:0]          root_next;
    logic                      sphere_pair;

    logic                      s2_valid_reg;
    cpo_pkg::outcome_t         s2_outcome_reg;
    logic                      s2_box_pair_reg;
    logic                      s2_bb_hit_reg;
    logic [MAG_W-1:0]          s2_mag_reg [AXES];
    logic [MAG_W-1:0]          s2_root_reg;

    // stage 3: squares
    logic [SQ_W-1:0]           sq_next [AXES];
    logic [SQ_W-1:0]           lim_next;

    logic                      s3_valid_reg;
    cpo_pkg::outcome_t         s3_outcome_reg;
    logic                      s3_box_pair_reg;
    logic                      s3_bb_hit_reg;
    logic [SQ_W-1:0]           s3_sq_reg [AXES];
    logic [SQ_W-1:0]           s3_lim_reg;

    // stage 4: sum, compare and result
    logic [SUM_W-1:0]          sum;
    logic                      hit;
    logic                      done_reg;
    logic                      done_next;
    logic                      contact_reg;
    logic                      contact_next;
    cpo_pkg::outcome_t         outcome_reg;

    // out of range operands read as disabled entries
    always_comb
    begin
        ta = ctl_in.range_a ? attr_a : '0;
        tb = ctl_in.range_b ? attr_b : '0;
        if (!ctl_in.is_test)
        begin
            s1_outcome_next = cpo_pkg::OUT_WRITE;
        end
        else if (!ta.enabled || !tb.enabled)
        begin
            s1_outcome_next = cpo_pkg::OUT_SKIP_DISABLED;
        end
        else if (((ta.layer & tb.mask) == '0) || ((tb.layer & ta.mask) == '0))
        begin
            s1_outcome_next = cpo_pkg::OUT_SKIP_LAYER;
        end
        else
        begin
            s1_outcome_next = cpo_pkg::OUT_TESTED;
        end
    end

    // box bounds of both entries, exact in 34 bits
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            a_c[k]       = BOUND_W'($signed(geom_a.pos[k]));
            b_c[k]       = BOUND_W'($signed(geom_b.pos[k]));
            a_lo_next[k] = a_c[k] - $signed(BOUND_W'(geom_a.ext[k]));
            a_hi_next[k] = a_c[k] + $signed(BOUND_W'(geom_a.ext[k]));
            b_lo_next[k] = b_c[k] - $signed(BOUND_W'(geom_b.ext[k]));
            b_hi_next[k] = b_c[k] + $signed(BOUND_W'(geom_b.ext[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        s1_outcome_reg <= s1_outcome_next;
        s1_sa_reg      <= ta.sphere;
        s1_sb_reg      <= tb.sphere;
        s1_ra_reg      <= geom_a.ext[0];
        s1_rb_reg      <= geom_b.ext[0];
        for (int k = 0; k < AXES; k++)
        begin
            s1_ca_reg[k]   <= a_c[k];
            s1_cb_reg[k]   <= b_c[k];
            s1_a_lo_reg[k] <= a_lo_next[k];
            s1_a_hi_reg[k] <= a_hi_next[k];
            s1_b_lo_reg[k] <= b_lo_next[k];
            s1_b_hi_reg[k] <= b_hi_next[k];
        end
    end

    // strict box overlap, centre distance and clamp distance per axis
    always_comb
    begin
        sphere_pair = s1_sa_reg && s1_sb_reg;
        for (int k = 0; k < AXES; k++)
        begin
            bb_axis[k] = (s1_a_lo_reg[k] < s1_b_hi_reg[k]) &&
                         (s1_a_hi_reg[k] > s1_b_lo_reg[k]);
            d_ab[k]    = s1_ca_reg[k] - s1_cb_reg[k];
            d_ba[k]    = s1_cb_reg[k] - s1_ca_reg[k];
            // sphere centre against the bounds of the box
            sp[k]      = s1_sa_reg ? s1_ca_reg[k] : s1_cb_reg[k];
            bx_lo[k]   = s1_sa_reg ? s1_b_lo_reg[k] : s1_a_lo_reg[k];
            bx_hi[k]   = s1_sa_reg ? s1_b_hi_reg[k] : s1_a_hi_reg[k];
            d_lo[k]    = bx_lo[k] - sp[k];
            d_hi[k]    = sp[k] - bx_hi[k];
            if (sphere_pair)
            begin
                mag_next[k] = (s1_ca_reg[k] >= s1_cb_reg[k]) ? d_ab[k][MAG_W-1:0]
                                                             : d_ba[k][MAG_W-1:0];
            end
            else if (sp[k] < bx_lo[k])
            begin
                mag_next[k] = d_lo[k][MAG_W-1:0];
            end
            else if (sp[k] > bx_hi[k])
            begin
                mag_next[k] = d_hi[k][MAG_W-1:0];
            end
            else
            begin
                mag_next[k] = '0;
            end
        end
        // radius sum for two spheres, sphere radius against a box
        if (sphere_pair)
        begin
            root_next = MAG_W'(s1_ra_reg) + MAG_W'(s1_rb_reg);
        end
        else
        begin
            root_next = MAG_W'(s1_sa_reg ? s1_ra_reg : s1_rb_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_outcome_reg  <= s1_outcome_reg;
        s2_box_pair_reg <= !s1_sa_reg && !s1_sb_reg;
        s2_bb_hit_reg   <= &bb_axis;
        s2_root_reg     <= root_next;
        for (int k = 0; k < AXES; k++)
        begin
            s2_mag_reg[k] <= mag_next[k];
        end
    end

    // one 32 by 32 square per axis plus the limit
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            sq_next[k] = SQ_W'(s2_mag_reg[k]) * SQ_W'(s2_mag_reg[k]);
        end
        lim_next = SQ_W'(s2_root_reg) * SQ_W'(s2_root_reg);
    end

    always_ff @(posedge clk)
    begin
        s3_outcome_reg  <= s2_outcome_reg;
        s3_box_pair_reg <= s2_box_pair_reg;
        s3_bb_hit_reg   <= s2_bb_hit_reg;
        s3_lim_reg      <= lim_next;
        for (int k = 0; k < AXES; k++)
        begin
            s3_sq_reg[k] <= sq_next[k];
        end
    end

    // exact squared distance against limit, box test for two boxes
    always_comb
    begin
        sum          = SUM_W'(s3_sq_reg[0]) + SUM_W'(s3_sq_reg[1]) + SUM_W'(s3_sq_reg[2]);
        hit          = s3_box_pair_reg ? s3_bb_hit_reg : (sum < SUM_W'(s3_lim_reg));
        done_next    = s3_valid_reg;
        contact_next = s3_valid_reg && (s3_outcome_reg == cpo_pkg::OUT_TESTED) && hit;
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= s3_outcome_reg;
    end

    // stage valids and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            contact_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= done_next;
            contact_reg  <= contact_next;
        end
    end

    assign done    = done_reg;
    assign contact = contact_reg;
    assign outcome = outcome_reg;

endmodule

`default_nettype wire

### sv/collider_pair_overlap_test.sv
// top level of the collider pair overlap tester
// done goes high once an item has passed the registered table read, the s1, s2 and s3 stages and the done register
// throughput: one item per cycle while busy is low, reads of both entries share the two table read ports
// results cannot be held off, so busy is low in every cycle after the clearing pass
// reset: busy stays high while the attribute table is cleared
`default_nettype none
`include "assert_macros.svh"

module collider_pair_overlap_test #(
    parameter int ENTRIES = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic [cpo_pkg::IDX_W-1:0]     index_a,
    input  wire logic [cpo_pkg::IDX_W-1:0]     index_b,
    input  wire logic signed [cpo_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [cpo_pkg::POS_W-1:0] pos_y,
    input  wire logic signed [cpo_pkg::POS_W-1:0] pos_z,
    input  wire logic [cpo_pkg::EXT_W-1:0]     extent_x,
    input  wire logic [cpo_pkg::EXT_W-1:0]     extent_y,
    input  wire logic [cpo_pkg::EXT_W-1:0]     extent_z,
    input  wire logic [1:0]                    shape_flags,
    input  wire logic [cpo_pkg::LAYER_W-1:0]   layer_bits,
    input  wire logic [cpo_pkg::LAYER_W-1:0]   mask_bits,
    output logic                               done,
    output logic                               contact,
    output logic [1:0]                         outcome
);

    localparam int AW = $clog2(ENTRIES);

    logic               accept;
    logic               clearing;
    logic               range_a;
    logic               range_b;
    logic               wr_en;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    cpo_pkg::geom_t     wr_geom;
    cpo_pkg::attr_t     wr_attr;
    cpo_pkg::geom_t     rd_geom_a;
    cpo_pkg::geom_t     rd_geom_b;
    cpo_pkg::attr_t     rd_attr_a;
    cpo_pkg::attr_t     rd_attr_b;
    cpo_pkg::item_ctl_t ctl_reg;
    cpo_pkg::item_ctl_t ctl_next;

    // item handshake and table addressing
    always_comb
    begin
        accept   = start && !clearing;
        range_a  = 32'(index_a) < 32'(ENTRIES);
        range_b  = 32'(index_b) < 32'(ENTRIES);
        addr_a   = AW'(index_a);
        addr_b   = AW'(index_b);
        wr_en    = accept && (operation == cpo_pkg::OP_WRITE) && range_a;
        wr_geom  = '{pos: {pos_z, pos_y, pos_x}, ext: {extent_z, extent_y, extent_x}};
        wr_attr  = '{mask: mask_bits, layer: layer_bits,
                     sphere: shape_flags[1], enabled: shape_flags[0]};
        ctl_next = '{valid: accept, is_test: (operation == cpo_pkg::OP_TEST),
                     range_a: range_a, range_b: range_b};
    end

    // item control lines up with the registered table reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    cpo_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (addr_a),
        .wr_geom   (wr_geom),
        .wr_attr   (wr_attr),
        .rd_en     (accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_geom_a (rd_geom_a),
        .rd_geom_b (rd_geom_b),
        .rd_attr_a (rd_attr_a),
        .rd_attr_b (rd_attr_b),
        .clearing  (clearing)
    );

    cpo_geom u_geom (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_reg),
        .geom_a  (rd_geom_a),
        .geom_b  (rd_geom_b),
        .attr_a  (rd_attr_a),
        .attr_b  (rd_attr_b),
        .done    (done),
        .contact (contact),
        .outcome (outcome)
    );

    assign busy = clearing;

    // every item taken while busy is low gives its result on done
    `CPO_ASSERT_IMPL(a_item_gives_result, clk, rst_n, start && !busy, ##5 done)
    // contact is only ever reported for a tested pair
    `CPO_ASSERT_IMPL(a_contact_tested, clk, rst_n, contact, outcome == cpo_pkg::OUT_TESTED)
    // once the clearing pass ends the block never stalls again
    `CPO_ASSERT_NEXT(a_busy_stays_low, clk, rst_n, !busy, !busy)

endmodule

`default_nettype wire
